FILE: hdl/hsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, sizes and codes of the homophonic substitution cipher core.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Key geometry
  localparam int ALPHABET       = 26;
  localparam int SYMBOL_SPACE   = 94;
  localparam int MAX_HOMOPHONES = 3;

  localparam int LETTER_W = $clog2(ALPHABET);
  localparam int SYM_W    = $clog2(SYMBOL_SPACE);
  localparam int HT_DEPTH = ALPHABET * MAX_HOMOPHONES;
  localparam int HT_AW    = $clog2(HT_DEPTH);

  // Character constants
  localparam logic [7:0]  SYM_LOW    = 8'd33;
  localparam logic [7:0]  SYM_HIGH   = 8'd126;
  localparam logic [7:0]  CH_A       = 8'd97;
  localparam logic [7:0]  CH_Z       = 8'd122;
  localparam logic [15:0] SEED_RESET = 16'd44257;

  // Request type codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ENCRYPT = 2'd1;
  localparam logic [1:0] REQ_DECRYPT = 2'd2;

  // Classified command kinds
  typedef enum logic [1:0] {
    K_LOAD   = 2'd0,
    K_ENC    = 2'd1,
    K_DEC    = 2'd2,
    K_REJECT = 2'd3
  } cmd_kind_t;

  // Command handed from the front end to the execution unit
  typedef struct packed {
    cmd_kind_t           kind;
    logic [LETTER_W-1:0] letter;
    logic [1:0]          slot;
    logic [1:0]          count;
    logic [SYM_W-1:0]    sym;
  } cmd_t;

  // Queue status seen by the execution unit
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: hdl/homophonic_substitution_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homophonic_substitution_cipher_core
// Homophonic substitution cipher with a loadable key: load, encrypt, decrypt.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   req_type, char, letter_index, slot,
//                                          homophone_count
//  out      output     out_valid/out_stall char, error
//  cfg      input      cfg_wr_en           cfg_wr_data (LFSR seed)
//
//  A request is queued in a two-entry queue the cycle it is accepted.
//  Loads and rejected requests are answered from the idle state; encrypt
//  and decrypt hits go through a wait state for the registered key RAM read.
//  Reset clears the letter counts and symbol valid bits at once; no sweep.
//  in_stall rises only while the queue is full; out_stall holds the result.
// ----------------------------------------------------------------------------
module homophonic_substitution_cipher_core import hsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_char,
  input  logic [4:0]  in_letter_index,
  input  logic [1:0]  in_slot,
  input  logic [1:0]  in_homophone_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_error
);

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;
  logic      pop;

  // Classify requests
  hsc_front u_front (
    .in_req_type        (in_req_type),
    .in_char            (in_char),
    .in_letter_index    (in_letter_index),
    .in_slot            (in_slot),
    .in_homophone_count (in_homophone_count),
    .cmd                (front_cmd)
  );

  // Decouple front end and execution
  hsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  assign in_stall = q_status.full;

  // Execute commands against the key
  hsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_cmd    (head_cmd),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_error   (out_error)
  );

endmodule

FILE: hdl/hsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/hsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_front
// Front end: range-checks an incoming request and turns it into a command.
// ----------------------------------------------------------------------------
module hsc_front import hsc_pkg::*; (
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char,
  input  logic [4:0] in_letter_index,
  input  logic [1:0] in_slot,
  input  logic [1:0] in_homophone_count,
  output cmd_t       cmd
);

  logic [7:0] sym_off;
  logic [7:0] let_off;
  logic       sym_ok;
  logic       plain_ok;
  logic       load_ok;

  // Offsets into the symbol space and the alphabet
  assign sym_off = in_char - SYM_LOW;
  assign let_off = in_char - CH_A;

  assign sym_ok   = (in_char >= SYM_LOW) && (in_char <= SYM_HIGH) &&
                    (sym_off < SYMBOL_SPACE);
  assign plain_ok = (in_char >= CH_A) && (in_char <= CH_Z) && (let_off < ALPHABET);
  assign load_ok  = sym_ok && (in_letter_index < ALPHABET) &&
                    (in_slot < MAX_HOMOPHONES) && (in_homophone_count != 2'd0) &&
                    (in_homophone_count <= MAX_HOMOPHONES);

  // Classify the request
  always_comb begin
    cmd.kind   = K_REJECT;
    cmd.letter = in_letter_index[LETTER_W-1:0];
    cmd.slot   = in_slot;
    cmd.count  = in_homophone_count;
    cmd.sym    = sym_off[SYM_W-1:0];
    case (in_req_type)
      REQ_LOAD: begin
        if (load_ok) begin
          cmd.kind = K_LOAD;
        end
      end
      REQ_ENCRYPT: begin
        cmd.letter = let_off[LETTER_W-1:0];
        if (plain_ok) begin
          cmd.kind = K_ENC;
        end
      end
      REQ_DECRYPT: begin
        if (sym_ok) begin
          cmd.kind = K_DEC;
        end
      end
      default: begin
        cmd.kind = K_REJECT;
      end
    endcase
  end

endmodule

FILE: hdl/hsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_queue
// Two-entry command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module hsc_queue import hsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push;
  logic       do_pop;

  assign status.empty = (fill_r == 2'd0);
  assign status.full  = (fill_r == 2'd2);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/hsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_back
// Execution unit: holds the key, the choice LFSR and the result register.
// ----------------------------------------------------------------------------
module hsc_back import hsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  cmd_t        head_cmd,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_error
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic              pend_enc_r, pend_enc_nxt;
  logic [15:0]       lfsr_r, lfsr_nxt;
  logic [1:0]        counts_r [ALPHABET];
  logic              inv_valid_r [SYMBOL_SPACE];
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_error_r, out_error_nxt;

  logic              out_free;
  logic [15:0]       lfsr_step;
  logic [1:0]        cur_count;
  logic [1:0]        pick;
  logic              key_we;
  logic              ht_re;
  logic              inv_re;
  logic [HT_AW-1:0]  ht_waddr;
  logic [HT_AW-1:0]  ht_raddr;
  logic [6:0]        ht_wdata;
  logic [6:0]        ht_rdata;
  logic [LETTER_W-1:0] inv_rdata;

  // Fibonacci LFSR x^16+x^14+x^13+x^11+1, shifting right
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

  // Residue modulo 3 by folding base-4 digits (4 == 1 mod 3)
  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    logic [1:0] r;
    s1 = 5'd0;
    for (int k = 0; k < 8; k++) begin
      s1 = s1 + {3'd0, v[2*k +: 2]};
    end
    s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'd0, s1[4]};
    s3 = {1'b0, s2[1:0]} + {2'd0, s2[2]};
    case (s3)
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      default: r = s3[1:0];
    endcase
    return r;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign lfsr_step = lfsr_next(lfsr_r);
  assign cur_count = counts_r[head_cmd.letter];

  // Pick the homophone slot from the stepped LFSR and the letter's count
  always_comb begin
    case (cur_count)
      2'd2:    pick = {1'b0, lfsr_step[0]};
      2'd3:    pick = mod3(lfsr_step);
      default: pick = 2'd0;
    endcase
  end

  assign ht_waddr = HT_AW'(head_cmd.letter * MAX_HOMOPHONES + head_cmd.slot);
  assign ht_raddr = HT_AW'(head_cmd.letter * MAX_HOMOPHONES + pick);
  assign ht_wdata = 7'({1'b0, head_cmd.sym} + SYM_LOW);

  // Sequence one command at a time
  always_comb begin
    state_nxt     = state_r;
    pend_enc_nxt  = pend_enc_r;
    lfsr_nxt      = lfsr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_error_nxt = out_error_r;
    pop           = 1'b0;
    key_we        = 1'b0;
    ht_re         = 1'b0;
    inv_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop = 1'b1;
          case (head_cmd.kind)
            K_LOAD: begin
              key_we        = 1'b1;
              out_valid_nxt = 1'b1;
              out_char_nxt  = 8'd0;
              out_error_nxt = 1'b0;
            end
            K_ENC: begin
              if (cur_count != 2'd0) begin
                lfsr_nxt     = lfsr_step;
                ht_re        = 1'b1;
                pend_enc_nxt = 1'b1;
                state_nxt    = ST_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = 8'd0;
                out_error_nxt = 1'b1;
              end
            end
            K_DEC: begin
              if (inv_valid_r[head_cmd.sym]) begin
                inv_re       = 1'b1;
                pend_enc_nxt = 1'b0;
                state_nxt    = ST_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = 8'd0;
                out_error_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = 8'd0;
              out_error_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_enc_r ? {1'b0, ht_rdata} : 8'(CH_A + inv_rdata);
          out_error_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Reload the seed, a zero seed becomes one
    if (cfg_wr_en) begin
      lfsr_nxt = (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lfsr_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_enc_r  <= pend_enc_nxt;
    out_char_r  <= out_char_nxt;
    out_error_r <= out_error_nxt;
  end

  // Letter counts and inverse valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        counts_r[i] <= 2'd0;
      end
      for (int i = 0; i < SYMBOL_SPACE; i++) begin
        inv_valid_r[i] <= 1'b0;
      end
    end else if (key_we) begin
      counts_r[head_cmd.letter]  <= head_cmd.count;
      inv_valid_r[head_cmd.sym]  <= 1'b1;
    end
  end

  // Homophone table: letter and slot to symbol
  hsc_ram #(
    .WIDTH (7),
    .DEPTH (HT_DEPTH)
  ) u_ht_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .re    (ht_re),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  // Inverse table: symbol to letter
  hsc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (SYMBOL_SPACE)
  ) u_inv_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (head_cmd.sym),
    .wdata (head_cmd.letter),
    .re    (inv_re),
    .raddr (head_cmd.sym),
    .rdata (inv_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_error = out_error_r;

endmodule

FILE: hdl/hsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level assertions for the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module hsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        out_error
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_error))
    else $error("stalled result dropped or changed");

  // Drop the character on a rejected request
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_char == 8'd0)
    else $error("rejected request carries a character");

  // Keep good results zero or within the printable range
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_char == 8'd0 || (out_char >= 8'd33 && out_char <= 8'd126))
    else $error("result character out of range");

  // Raise in_stall only after a request was taken
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !in_stall |=> !in_stall)
    else $error("input stalled without a new request");

  // Clear both sides after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind homophonic_substitution_cipher_core hsc_checker u_hsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_error (out_error)
);

FILE: tb/homophonic_substitution_cipher_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homophonic_substitution_cipher_core_test
// Self-checking bench for the homophonic substitution cipher core. Loads key
// entries, encrypts and decrypts through the request channel while both
// sides idle at random, predicts every result from a private copy of the
// key and the choice LFSR, and compares each result against the oldest
// prediction. The seed register is rewritten between phases.
// ----------------------------------------------------------------------------
import hsc_pkg::*;

// One request as offered on the input channel
typedef struct packed {
  logic [1:0] req;
  logic [7:0] ch;
  logic [4:0] letter;
  logic [1:0] slot;
  logic [1:0] count;
} cipher_req_t;

// One predicted result
typedef struct packed {
  logic [7:0] ch;
  logic       err;
} cipher_res_t;

// Key shadow and result store
class cipher_scoreboard;
  logic [6:0]  key_sym [ALPHABET][MAX_HOMOPHONES];
  bit          key_written [ALPHABET][MAX_HOMOPHONES];
  logic [1:0]  key_count [ALPHABET];
  logic [4:0]  sym_letter [SYMBOL_SPACE];
  bit          sym_valid [SYMBOL_SPACE];
  logic [15:0] choice_lfsr;
  cipher_res_t expected_q [$];
  int          errors;

  function new();
    foreach (key_count[l]) key_count[l] = 2'd0;
    foreach (key_written[l, s]) key_written[l][s] = 1'b0;
    foreach (key_sym[l, s]) key_sym[l][s] = 7'd0;
    foreach (sym_valid[i]) sym_valid[i] = 1'b0;
    foreach (sym_letter[i]) sym_letter[i] = 5'd0;
    choice_lfsr = SEED_RESET;
    errors      = 0;
  endfunction

  // A zero seed is forced to one so the LFSR cannot lock up
  function void load_seed(logic [15:0] seed);
    choice_lfsr = (seed == 16'd0) ? 16'd1 : seed;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Update the key shadow and queue the result of an accepted request
  function void note_request(cipher_req_t r);
    cipher_res_t res;
    int          l;
    int          pick;
    bit          sym_ok;

    res.ch  = 8'd0;
    res.err = 1'b1;
    sym_ok  = (r.ch >= SYM_LOW) && (r.ch <= SYM_HIGH);
    case (r.req)
      REQ_LOAD: begin
        if (sym_ok && r.letter < ALPHABET && r.slot < MAX_HOMOPHONES &&
            r.count >= 1 && r.count <= MAX_HOMOPHONES) begin
          key_sym[r.letter][r.slot]     = r.ch[6:0];
          key_written[r.letter][r.slot] = 1'b1;
          key_count[r.letter]           = r.count;
          sym_letter[r.ch - SYM_LOW]    = r.letter;
          sym_valid[r.ch - SYM_LOW]     = 1'b1;
          res.err                       = 1'b0;
        end
      end
      REQ_ENCRYPT: begin
        if (r.ch >= CH_A && r.ch <= CH_Z && key_count[r.ch - CH_A] != 2'd0) begin
          l           = r.ch - CH_A;
          choice_lfsr = {choice_lfsr[0] ^ choice_lfsr[2] ^ choice_lfsr[3] ^ choice_lfsr[5],
                         choice_lfsr[15:1]};
          pick        = int'(choice_lfsr) % int'(key_count[l]);
          res.ch      = {1'b0, key_sym[l][pick]};
          res.err     = 1'b0;
        end
      end
      REQ_DECRYPT: begin
        if (sym_ok && sym_valid[r.ch - SYM_LOW]) begin
          res.ch  = CH_A + sym_letter[r.ch - SYM_LOW];
          res.err = 1'b0;
        end
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endfunction

  // Compare one accepted result with the oldest prediction
  function void check_result(logic [7:0] ch, logic err);
    cipher_res_t exp_res;

    if (expected_q.size() == 0) begin
      $error("unexpected result: out_char %0h, error %0b", ch, err);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (ch !== exp_res.ch) begin
      $error("out_char: expected %0h, actual %0h", exp_res.ch, ch);
      errors++;
    end
    if (err !== exp_res.err) begin
      $error("out_error: expected %0b, actual %0b", exp_res.err, err);
      errors++;
    end
  endfunction
endclass

module homophonic_substitution_cipher_core_test;

  localparam logic [1:0] REQ_INVALID     = 2'd3;
  localparam int         ITEMS_PER_PHASE = 406;
  localparam int         HOLD_CYCLES     = 150;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam int         TAIL_CYCLES     = 8;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        cfg_wr_en          = 1'b0;
  logic [15:0] cfg_wr_data        = 16'd0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type        = REQ_LOAD;
  logic [7:0]  in_char            = 8'd0;
  logic [4:0]  in_letter_index    = 5'd0;
  logic [1:0]  in_slot            = 2'd0;
  logic [1:0]  in_homophone_count = 2'd0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [7:0]  out_char;
  logic        out_error;

  cipher_scoreboard sb;
  int               send_idle_pct    = 0;
  int               recv_idle_pct    = 0;
  bit               hold_off_pending = 1'b0;
  int               idle_cycles      = 0;
  cipher_req_t      directed_q [$];

  homophonic_substitution_cipher_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_char            (in_char),
    .in_letter_index    (in_letter_index),
    .in_slot            (in_slot),
    .in_homophone_count (in_homophone_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char           (out_char),
    .out_error          (out_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic cipher_req_t mk(logic [1:0] req, logic [7:0] ch, logic [4:0] letter,
                                     logic [1:0] slot, logic [1:0] count);
    cipher_req_t r;
    r.req    = req;
    r.ch     = ch;
    r.letter = letter;
    r.slot   = slot;
    r.count  = count;
    return r;
  endfunction

  // First slot below the count that was never written, or -1 if the letter is safe
  function automatic int missing_slot(int l);
    for (int s = 0; s < sb.key_count[l]; s++) begin
      if (!sb.key_written[l][s]) return s;
    end
    return -1;
  endfunction

  // Mostly well-formed key traffic, with bad loads, noise bytes and bad types
  function automatic cipher_req_t random_request();
    cipher_req_t r;
    int          pick;
    int          l;
    int          s;

    r.req    = REQ_LOAD;
    r.ch     = 8'($urandom);
    r.letter = 5'($urandom);
    r.slot   = 2'($urandom);
    r.count  = 2'($urandom);
    pick     = $urandom_range(99);
    if (pick < 28) begin
      r.letter = 5'($urandom_range(ALPHABET - 1));
      r.slot   = 2'($urandom_range(MAX_HOMOPHONES - 1));
      r.count  = 2'($urandom_range(MAX_HOMOPHONES, 1));
      r.ch     = 8'($urandom_range(SYM_HIGH, SYM_LOW));
      // corrupt one field of a few loads
      if (pick < 5) begin
        case ($urandom_range(3))
          0: r.ch = 8'($urandom_range(1) ? $urandom_range(32, 0) : $urandom_range(255, 127));
          1: r.letter = 5'($urandom_range(31, ALPHABET));
          2: r.slot = 2'd3;
          default: r.count = 2'd0;
        endcase
      end
    end else if (pick < 62) begin
      r.req = REQ_ENCRYPT;
      if (pick < 56) begin
        l = $urandom_range(ALPHABET - 1);
        s = missing_slot(l);
        if (s < 0) begin
          r.ch = 8'(CH_A + l);
        end else begin
          // fill the gap first so that no unwritten slot is ever chosen
          r.req    = REQ_LOAD;
          r.letter = 5'(l);
          r.slot   = 2'(s);
          r.count  = sb.key_count[l];
          r.ch     = 8'($urandom_range(SYM_HIGH, SYM_LOW));
        end
      end else if (r.ch >= CH_A && r.ch <= CH_Z && missing_slot(r.ch - CH_A) >= 0) begin
        r.ch = r.ch ^ 8'h80;
      end
    end else if (pick < 92) begin
      r.req = REQ_DECRYPT;
      if (pick < 84) begin
        l = $urandom_range(ALPHABET - 1);
        s = $urandom_range(MAX_HOMOPHONES - 1);
        r.ch = sb.key_written[l][s] ? {1'b0, sb.key_sym[l][s]}
                                    : 8'($urandom_range(SYM_HIGH, SYM_LOW));
      end
    end else begin
      r.req = REQ_INVALID;
    end
    return r;
  endfunction

  // Offer one request, idling first at random, and note it once accepted
  task automatic send_request(input cipher_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= r.req;
    in_char            <= r.ch;
    in_letter_index    <= r.letter;
    in_slot            <= r.slot;
    in_homophone_count <= r.count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [15:0] seed);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.load_seed(seed);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      send_request(random_request());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Check results and watch for a hung channel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_char, out_error);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sb = new();

    // unloaded letter and unknown symbol on an empty key
    directed_q.push_back(mk(REQ_ENCRYPT, CH_A, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_DECRYPT, SYM_LOW, 5'd31, 2'd3, 2'd3));
    // key extremes: first and last letter, lowest and highest symbol
    directed_q.push_back(mk(REQ_LOAD, SYM_LOW, 5'd0, 2'd0, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, SYM_HIGH, 5'd25, 2'd0, 2'd3));
    directed_q.push_back(mk(REQ_LOAD, 8'd64, 5'd25, 2'd1, 2'd3));
    directed_q.push_back(mk(REQ_LOAD, 8'd100, 5'd25, 2'd2, 2'd3));
    directed_q.push_back(mk(REQ_ENCRYPT, CH_A, 5'd31, 2'd3, 2'd3));
    directed_q.push_back(mk(REQ_ENCRYPT, CH_Z, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_ENCRYPT, CH_Z, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_ENCRYPT, CH_Z, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_DECRYPT, SYM_LOW, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_DECRYPT, SYM_HIGH, 5'd0, 2'd0, 2'd0));
    // bad loads: symbol out of range, letter out of range, bad slot, zero count; bad type
    directed_q.push_back(mk(REQ_LOAD, 8'd32, 5'd1, 2'd0, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, 8'd127, 5'd1, 2'd0, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, 8'd50, 5'd26, 2'd0, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, 8'd50, 5'd31, 2'd0, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, 8'd50, 5'd1, 2'd3, 2'd1));
    directed_q.push_back(mk(REQ_LOAD, 8'd50, 5'd1, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_INVALID, CH_A, 5'd0, 2'd0, 2'd1));
    // illegal plaintext bytes either side of the letters and at the ends
    directed_q.push_back(mk(REQ_ENCRYPT, 8'd96, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_ENCRYPT, 8'd123, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_ENCRYPT, 8'd0, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_ENCRYPT, 8'd255, 5'd0, 2'd0, 2'd0));
    // unknown symbols just outside the symbol range
    directed_q.push_back(mk(REQ_DECRYPT, 8'd127, 5'd0, 2'd0, 2'd0));
    directed_q.push_back(mk(REQ_DECRYPT, 8'd32, 5'd0, 2'd0, 2'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: reset seed, sender idles lightly, receiver heavily
    send_idle_pct = 22;
    recv_idle_pct = 67;
    foreach (directed_q[i]) send_request(directed_q[i]);
    run_random(ITEMS_PER_PHASE);

    // phase two: zero seed, idling swapped
    drain();
    write_seed(16'h0000);
    send_idle_pct = 67;
    recv_idle_pct = 22;
    run_random(ITEMS_PER_PHASE);

    // phase three: all-ones seed, no idling, one long receiver hold-off
    drain();
    write_seed(16'hFFFF);
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_pending = 1'b1;
    run_random(ITEMS_PER_PHASE);

    // phase four: random seed, no idling
    drain();
    write_seed(16'($urandom_range(16'hFFFE, 2)));
    run_random(ITEMS_PER_PHASE);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/hsc_pkg.sv
hdl/hsc_ram.sv
hdl/hsc_front.sv
hdl/hsc_queue.sv
hdl/hsc_back.sv
hdl/homophonic_substitution_cipher_core.sv
hdl/hsc_checker.sv
tb/homophonic_substitution_cipher_core_test.sv
